/* src/msched_pkg.sv */
// ----------------------------------------------------------------------------
// msched_pkg
// Shared types and constants of the multi-policy task scheduler: payload
// words, policy and register codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package msched_pkg;

    // task table depth; slot fields below are sized for it
    localparam int MAX_TASKS = 16;

    // input word function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // scheduling policies
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_SJF  = 2'd2;
    localparam logic [1:0] POL_PSJF = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_POLICY     = 2'd0;
    localparam logic [1:0] REG_QUANTUM    = 2'd1;
    localparam logic [1:0] REG_TASK_COUNT = 2'd2;

    localparam logic [15:0] RESET_QUANTUM    = 16'd500;
    localparam logic [4:0]  RESET_TASK_COUNT = 5'd16;

    typedef struct packed {
        logic        func;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
    } t_sched_in;

    typedef struct packed {
        logic [31:0] tick_time;
        logic        run_valid;
        logic [3:0]  run_slot;
        logic        finish_valid;
        logic [3:0]  finish_slot;
        logic        all_done;
    } t_sched_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // write a task slot from the input word
        logic ret;       // retire check, per-tick init
        logic div_step;  // one bit of the slice remainder
        logic mod_step;  // one subtract of the rotate start reduction
        logic scan;      // release / selection scan
        logic pick;      // commit the selected task
        logic dec;       // burn one tick of work, advance time
        logic emit;      // register the result word
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic halt;      // all done: tick ends after the retire check
        logic rr_need;   // round robin with a task still running
        logic div_last;  // last remainder step
        logic mod_done;  // rotate start below slot count
        logic scan_last; // last slot processed this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

/* src/msched_ram.sv */
// ----------------------------------------------------------------------------
// msched_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msched_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/msched_ctrl.sv */
// ----------------------------------------------------------------------------
// msched_ctrl
// Tick sequencer: retire check, slice remainder, rotate start, slot scan,
// pick, work update. Drives the datapath by command word only.
// ----------------------------------------------------------------------------
`default_nettype none

module msched_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_func,
    input  wire msched_pkg::t_dp_sts  i_sts,
    output      msched_pkg::t_dp_cmd  o_cmd,
    output      logic                 o_busy
);

    import msched_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RET  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_MOD  = 8'b0000_1000,
        S_SCAN = 8'b0001_0000,
        S_PICK = 8'b0010_0000,
        S_RD   = 8'b0100_0000,
        S_DEC  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_func == FUNC_TICK) begin
                        n_state = S_RET;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_RET: begin
                o_cmd.ret = 1'b1;
                if (i_sts.halt) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_sts.rr_need) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_RD;
            end
            S_RD: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec  = 1'b1;
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // a tick word always starts with the retire check
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_func == FUNC_TICK) |=> (r_state == S_RET))
        else $error("tick word did not enter retire check");

    // a result word closes the tick
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("sequencer busy after result word");

    // scan hands over to pick once the last slot is processed
    a_scan_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_last) |=> (r_state == S_PICK))
        else $error("scan did not hand over to pick");

endmodule

`default_nettype wire

/* src/msched_dp.sv */
// ----------------------------------------------------------------------------
// msched_dp
// Scheduler datapath: task table RAM, release mask, running task state,
// bit-serial slice remainder, slot scan with min/first trackers, result word.
// ----------------------------------------------------------------------------
`default_nettype none

module msched_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire msched_pkg::t_sched_in  i_in,
    input  wire msched_pkg::t_dp_cmd    i_cmd,
    input  wire logic [1:0]             i_policy,
    input  wire logic [15:0]            i_quantum,
    input  wire logic [4:0]             i_task_count,
    output      msched_pkg::t_dp_sts    o_sts,
    output      logic                   o_valid,
    output      msched_pkg::t_sched_out o_out
);

    import msched_pkg::*;

    localparam int SW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int SSW  = SW + 1;
    localparam int CMPW = (SSW > 5) ? SSW : 5;

    // table RAM: {arrival, remaining}
    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [SW-1:0] ram_raddr;
    logic [31:0]   rd_data;
    logic [15:0]   rd_arr;
    logic [15:0]   rd_rem;

    // control state
    logic [MAX_TASKS-1:0] r_rel,       n_rel;
    logic                 r_rv,        n_rv;
    logic [SW-1:0]        r_rs,        n_rs;
    logic [4:0]           r_ret_cnt,   n_ret_cnt;
    logic [31:0]          r_ct,        n_ct;
    logic [31:0]          r_sw,        n_sw;
    logic                 r_fin,       n_fin;
    logic                 r_fin_v,     n_fin_v;
    logic [SSW-1:0]       r_idx,       n_idx;
    logic                 r_pv,        n_pv;
    logic                 r_best_v,    n_best_v;
    logic                 r_first_v,   n_first_v;
    logic                 r_after_v,   n_after_v;
    logic                 r_valid,     n_valid;

    // payload
    logic [3:0]           r_fin_s,     n_fin_s;
    logic [SW-1:0]        r_pidx,      n_pidx;
    logic [SW-1:0]        r_best_s,    n_best_s;
    logic [15:0]          r_best_key,  n_best_key;
    logic [SW-1:0]        r_first_s,   n_first_s;
    logic [SW-1:0]        r_after_s,   n_after_s;
    logic [31:0]          r_dvd,       n_dvd;
    logic [15:0]          r_drem,      n_drem;
    logic [4:0]           r_dcnt,      n_dcnt;
    logic [SSW-1:0]       r_start,     n_start;
    t_sched_out           r_out,       n_out;

    logic [4:0]    use_cnt;
    logic [CMPW-1:0] use_cmp;
    logic          retire;
    logic [4:0]    ret_cnt_inc;
    logic          fin_now;
    logic [15:0]   q_eff;
    logic [16:0]   trial;
    logic [15:0]   drem_nx;
    logic          issue;
    logic          match;
    logic          elig;
    logic [15:0]   key;
    logic          pick_v;
    logic [SW-1:0] pick_s;
    logic          load_we;
    logic          dec_we;
    logic [15:0]   burst_fix;

    msched_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TASKS)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    assign rd_arr = rd_data[31:16];
    assign rd_rem = rd_data[15:0];

    // slots in use, clamped to 1..MAX_TASKS
    always_comb begin
        if (i_task_count == 5'd0) begin
            use_cnt = 5'd1;
        end else if (32'(i_task_count) > 32'(MAX_TASKS)) begin
            use_cnt = 5'(MAX_TASKS);
        end else begin
            use_cnt = i_task_count;
        end
    end
    assign use_cmp = CMPW'(use_cnt);

    // retire check on the running slot (read address is r_rs while idle)
    assign retire      = r_rv && (rd_rem == 16'd0) && !r_fin;
    assign ret_cnt_inc = r_ret_cnt + 5'd1;
    assign fin_now     = retire && (ret_cnt_inc >= use_cnt);

    // restoring remainder, one dividend bit per step
    assign q_eff   = (i_quantum == 16'd0) ? 16'd1 : i_quantum;
    assign trial   = {r_drem, r_dvd[31]};
    assign drem_nx = (trial >= {1'b0, q_eff}) ? 16'(trial - {1'b0, q_eff}) : trial[15:0];

    // scan: issue one address a cycle, process the slot read last cycle
    assign issue = CMPW'(r_idx) < use_cmp;
    assign match = ({16'd0, rd_arr} == r_ct);
    assign elig  = r_pv && (r_rel[r_pidx] || match) && (rd_rem != 16'd0);
    assign key   = (i_policy == POL_FIFO) ? rd_arr : rd_rem;

    assign ram_raddr = i_cmd.scan ? r_idx[SW-1:0] : r_rs;

    // selection by policy
    always_comb begin
        pick_v = 1'b0;
        pick_s = r_rs;
        case (i_policy)
            POL_FIFO, POL_SJF: begin
                if (r_rv) begin
                    pick_v = 1'b1;
                end else begin
                    pick_v = r_best_v;
                    pick_s = r_best_s;
                end
            end
            POL_RR: begin
                if (!r_rv) begin
                    pick_v = r_first_v;
                    pick_s = r_first_s;
                end else if (r_drem != 16'd0) begin
                    pick_v = 1'b1;
                end else if (r_after_v) begin
                    pick_v = 1'b1;
                    pick_s = r_after_s;
                end else if (r_first_v) begin
                    pick_v = 1'b1;
                    pick_s = r_first_s;
                end else begin
                    pick_v = 1'b1;
                end
            end
            default: begin
                pick_v = r_best_v;
                pick_s = r_best_s;
            end
        endcase
    end

    // table writes: loads from idle, work decrement at end of tick
    assign burst_fix = (i_in.burst == 16'd0) ? 16'd1 : i_in.burst;
    assign load_we   = i_cmd.load && (32'(i_in.slot) < 32'(MAX_TASKS));
    assign dec_we    = i_cmd.dec && r_rv && (rd_rem != 16'd0);
    assign ram_we    = load_we || dec_we;
    assign ram_waddr = i_cmd.dec ? r_rs : SW'(i_in.slot);
    assign ram_wdata = i_cmd.dec ? {rd_arr, rd_rem - 16'd1} : {i_in.arrival, burst_fix};

    always_comb begin
        n_rel      = r_rel;
        n_rv       = r_rv;
        n_rs       = r_rs;
        n_ret_cnt  = r_ret_cnt;
        n_ct       = r_ct;
        n_sw       = r_sw;
        n_fin      = r_fin;
        n_fin_v    = r_fin_v;
        n_fin_s    = r_fin_s;
        n_idx      = r_idx;
        n_pv       = r_pv;
        n_pidx     = r_pidx;
        n_best_v   = r_best_v;
        n_best_s   = r_best_s;
        n_best_key = r_best_key;
        n_first_v  = r_first_v;
        n_first_s  = r_first_s;
        n_after_v  = r_after_v;
        n_after_s  = r_after_s;
        n_dvd      = r_dvd;
        n_drem     = r_drem;
        n_dcnt     = r_dcnt;
        n_start    = r_start;
        n_valid    = i_cmd.emit;
        n_out      = r_out;

        if (i_cmd.ret) begin
            n_fin_v = retire;
            n_fin_s = retire ? 4'(r_rs) : 4'd0;
            if (retire) begin
                n_rv      = 1'b0;
                n_ret_cnt = ret_cnt_inc;
                n_fin     = r_fin || fin_now;
            end
            n_idx     = '0;
            n_pv      = 1'b0;
            n_best_v  = 1'b0;
            n_first_v = 1'b0;
            n_after_v = 1'b0;
            n_dvd     = r_ct - r_sw;
            n_drem    = 16'd0;
            n_dcnt    = 5'd0;
            n_start   = SSW'(r_rs) + SSW'(1);
        end

        if (i_cmd.div_step) begin
            n_drem = drem_nx;
            n_dvd  = {r_dvd[30:0], 1'b0};
            n_dcnt = r_dcnt + 5'd1;
        end

        if (i_cmd.mod_step) begin
            n_start = SSW'(CMPW'(r_start) - use_cmp);
        end

        if (i_cmd.scan) begin
            n_pv   = issue;
            n_pidx = r_idx[SW-1:0];
            if (issue) begin
                n_idx = r_idx + SSW'(1);
            end
            if (r_pv && match) begin
                n_rel[r_pidx] = 1'b1;
            end
            if (elig) begin
                if (!r_best_v || key < r_best_key) begin
                    n_best_v   = 1'b1;
                    n_best_s   = r_pidx;
                    n_best_key = key;
                end
                if (!r_first_v) begin
                    n_first_v = 1'b1;
                    n_first_s = r_pidx;
                end
                if (!r_after_v && CMPW'(r_pidx) >= CMPW'(r_start)) begin
                    n_after_v = 1'b1;
                    n_after_s = r_pidx;
                end
            end
        end

        if (i_cmd.pick && pick_v && (!r_rv || pick_s != r_rs)) begin
            n_rv = 1'b1;
            n_rs = pick_s;
            n_sw = r_ct;
        end

        if (i_cmd.dec) begin
            n_ct = r_ct + 32'd1;
        end

        if (i_cmd.emit) begin
            n_out.tick_time = r_ct;
            if (i_cmd.ret) begin
                // tick ended by the retire check: nothing ran
                n_out.run_valid    = 1'b0;
                n_out.run_slot     = 4'd0;
                n_out.finish_valid = retire;
                n_out.finish_slot  = retire ? 4'(r_rs) : 4'd0;
                n_out.all_done     = 1'b1;
            end else begin
                n_out.run_valid    = r_rv;
                n_out.run_slot     = r_rv ? 4'(r_rs) : 4'd0;
                n_out.finish_valid = r_fin_v;
                n_out.finish_slot  = r_fin_s;
                n_out.all_done     = r_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel     <= '0;
            r_rv      <= 1'b0;
            r_rs      <= '0;
            r_ret_cnt <= 5'd0;
            r_ct      <= 32'd0;
            r_sw      <= 32'd0;
            r_fin     <= 1'b0;
            r_fin_v   <= 1'b0;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_best_v  <= 1'b0;
            r_first_v <= 1'b0;
            r_after_v <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_rel     <= n_rel;
            r_rv      <= n_rv;
            r_rs      <= n_rs;
            r_ret_cnt <= n_ret_cnt;
            r_ct      <= n_ct;
            r_sw      <= n_sw;
            r_fin     <= n_fin;
            r_fin_v   <= n_fin_v;
            r_idx     <= n_idx;
            r_pv      <= n_pv;
            r_best_v  <= n_best_v;
            r_first_v <= n_first_v;
            r_after_v <= n_after_v;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin_s    <= n_fin_s;
        r_pidx     <= n_pidx;
        r_best_s   <= n_best_s;
        r_best_key <= n_best_key;
        r_first_s  <= n_first_s;
        r_after_s  <= n_after_s;
        r_dvd      <= n_dvd;
        r_drem     <= n_drem;
        r_dcnt     <= n_dcnt;
        r_start    <= n_start;
        r_out      <= n_out;
    end

    assign o_sts.halt      = r_fin || fin_now;
    assign o_sts.rr_need   = (i_policy == POL_RR) && r_rv && !retire;
    assign o_sts.div_last  = (r_dcnt == 5'd31);
    assign o_sts.mod_done  = CMPW'(r_start) < use_cmp;
    assign o_sts.scan_last = r_pv && ((CMPW'(r_pidx) + CMPW'(1)) == use_cmp);

    assign o_valid = r_valid;
    assign o_out   = r_out;

    // nothing runs once every task in use has retired
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !r_rv)
        else $error("task running after all done");

    // a committed pick leaves the chosen slot running
    a_pick_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pick && pick_v) |=> (r_rv && r_rs == $past(pick_s)))
        else $error("pick not committed to running slot");

endmodule

`default_nettype wire

/* src/multi_policy_task_scheduler.sv */
// ----------------------------------------------------------------------------
// multi_policy_task_scheduler
// Tick-driven task scheduler with FIFO, round robin, SJF and preemptive SJF
// policies over a table of task slots, configured through an APB port.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                      Word
// -------   ---------  -----------------------------  --------------------------
// command   in         start && !busy                 i_in  (t_sched_in)
// result    out        o_valid, one cycle, no stall   o_out (t_sched_out)
// config    in/out     psel && penable (pready = 1)   policy, quantum, task_count
//
// Sequence: a load word is written from idle and does not raise busy. A tick
//   word holds busy through the retire check, the slot scan over the n slots
//   in use (through the table RAM's single read port), pick, table read and
//   decrement. Round robin with a task running first adds 32 steps of
//   bit-serial slice remainder, a state to settle the rotate start and the
//   subtract steps that bring the rotate start below n. A tick that ends at the
//   retire check (all done) returns to idle from there. Reset: synchronous,
//   active low; clears scheduler state and loads the register defaults. The
//   task table itself is not cleared. Stalls: the result word is shown for one
//   cycle and the receiver cannot hold it off; input is held off by busy.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_policy_task_scheduler (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // command channel
    input  wire logic                   start,
    output      logic                   busy,
    input  wire msched_pkg::t_sched_in  i_in,

    // result channel
    output      logic                   o_valid,
    output      msched_pkg::t_sched_out o_out,

    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output      logic [31:0]            prdata,
    output      logic                   pready
);

    import msched_pkg::*;

    logic [1:0]  r_policy,     n_policy;
    logic [15:0] r_quantum,    n_quantum;
    logic [4:0]  r_task_count, n_task_count;
    logic        cfg_wr;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // ---- configuration registers ------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_policy     = r_policy;
        n_quantum    = r_quantum;
        n_task_count = r_task_count;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_POLICY:     n_policy     = pwdata[1:0];
                REG_QUANTUM:    n_quantum    = pwdata[15:0];
                REG_TASK_COUNT: n_task_count = pwdata[4:0];
                default:        ;   // unmapped: write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_FIFO;
            r_quantum    <= RESET_QUANTUM;
            r_task_count <= RESET_TASK_COUNT;
        end else begin
            r_policy     <= n_policy;
            r_quantum    <= n_quantum;
            r_task_count <= n_task_count;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_POLICY:     prdata = {30'd0, r_policy};
            REG_QUANTUM:    prdata = {16'd0, r_quantum};
            REG_TASK_COUNT: prdata = {27'd0, r_task_count};
            default:        prdata = 32'd0;
        endcase
    end

    // ---- sequencer ---------------------------------------------------------
    // Walks each tick: retire check -> [slice remainder -> rotate start]
    // -> slot scan -> pick -> table read -> decrement and result.
    msched_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_in.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // ---- datapath ----------------------------------------------------------
    // Task table RAM, release mask, running task, time and result register.
    msched_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cmd        (cmd),
        .i_policy     (r_policy),
        .i_quantum    (r_quantum),
        .i_task_count (r_task_count),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

/* test/multi_policy_task_scheduler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_policy_task_scheduler_test
// Self-checking bench for the task scheduler. The stimulus fills every task
// slot, then runs phases that reprogram policy, slice and slot count through
// the APB port. Each phase issues task reloads and ticks, with random gaps
// except in steady phases, and the last phase runs the scheduler into its
// all-done state. A local scheduler model predicts every tick word, and
// the bench compares each result field and each register read-back.
// ----------------------------------------------------------------------------

module multi_policy_task_scheduler_test;

    import msched_pkg::*;

    localparam int SLOTS          = 16;
    localparam int SETTLE_CYCLES  = 80;    // exceeds the longest tick
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any word moving
    localparam int LONG_BURST     = 2000;  // no retirement within one phase
    localparam int PHASES         = 28;

    // no package code for the unused register address
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [1:0] POLICY_ORDER [4] = '{POL_FIFO, POL_RR, POL_SJF, POL_PSJF};

    // ------------------------------------------------------------------
    // clock, reset, DUT pins
    // ------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_sched_in   i_in    = '0;
    logic        o_valid;
    t_sched_out  o_out;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    multi_policy_task_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // scheduler model state (mirrors the DUT registers and task table)
    // ------------------------------------------------------------------
    logic [1:0]  sched_policy = POL_FIFO;
    logic [15:0] slice_len    = RESET_QUANTUM;
    logic [4:0]  slots_cfg    = RESET_TASK_COUNT;

    logic [15:0] task_arrival [SLOTS];
    logic [15:0] task_left    [SLOTS];
    logic [15:0] ready_mask   = '0;   // released slots
    logic        cur_valid    = 1'b0;
    logic [3:0]  cur_slot     = '0;
    logic [4:0]  retire_cnt   = '0;
    logic [31:0] clock_now    = '0;
    logic [31:0] slice_start  = '0;   // time of the last task switch
    logic        halted       = 1'b0;

    // bench bookkeeping
    t_sched_in   word_backlog [$];     // words waiting for the driver
    t_sched_out  tick_results_due [$]; // predicted result words, oldest first
    int          words_queued = 0;
    int          words_taken  = 0;
    int          results_seen = 0;
    int          mismatches   = 0;
    bit          steady_feed  = 1'b0;  // phase without input gaps
    int          gap_left     = 0;

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic bit can_run(int s);
        return ready_mask[s] && task_left[s] != 16'd0;
    endfunction

    // lowest slot holding the smallest key among runnable slots, -1 if none
    function automatic int pick_lowest(int n, bit by_arrival);
        int          best;
        logic [15:0] best_key;
        logic [15:0] key;
        best     = -1;
        best_key = '0;
        for (int i = 0; i < n; i++) begin
            if (!can_run(i)) continue;
            key = by_arrival ? task_arrival[i] : task_left[i];
            if (best < 0 || key < best_key) begin
                best     = i;
                best_key = key;
            end
        end
        return best;
    endfunction

    function automatic int rotate_pick(int n);
        logic [31:0] q;
        logic [31:0] elapsed;
        int          s;
        if (!cur_valid) begin
            for (int i = 0; i < n; i++)
                if (can_run(i)) return i;
            return -1;
        end
        q       = (slice_len == 16'd0) ? 32'd1 : {16'd0, slice_len};
        elapsed = clock_now - slice_start;
        if (elapsed % q != 32'd0) return int'(cur_slot);
        // slice over: next runnable slot after the current one, wrapping
        s = (int'(cur_slot) + 1) % n;
        for (int k = 0; k < n; k++) begin
            if (can_run(s)) return s;
            s = (s + 1) % n;
        end
        return int'(cur_slot);   // nobody else ready, keep running
    endfunction

    function automatic void store_task(t_sched_in w);
        task_arrival[w.slot] = w.arrival;
        task_left[w.slot]    = (w.burst == 16'd0) ? 16'd1 : w.burst;
    endfunction

    function automatic t_sched_out run_tick();
        t_sched_out r;
        int         n;
        int         nxt;
        logic       fin_v;
        logic [3:0] fin_s;
        n = (slots_cfg == 5'd0) ? 1 : (slots_cfg > 5'(SLOTS)) ? SLOTS : int'(slots_cfg);
        r           = '0;
        r.tick_time = clock_now;
        fin_v       = 1'b0;
        fin_s       = '0;

        // retire a running task that ran out of work
        if (!halted && cur_valid && task_left[cur_slot] == 16'd0) begin
            fin_v      = 1'b1;
            fin_s      = cur_slot;
            cur_valid  = 1'b0;
            retire_cnt = retire_cnt + 5'd1;
            if (int'(retire_cnt) >= n) halted = 1'b1;
        end

        if (!halted) begin
            for (int i = 0; i < n; i++)
                if ({16'd0, task_arrival[i]} == clock_now) ready_mask[i] = 1'b1;

            case (sched_policy)
                POL_FIFO: nxt = cur_valid ? int'(cur_slot) : pick_lowest(n, 1'b1);
                POL_RR:   nxt = rotate_pick(n);
                POL_SJF:  nxt = cur_valid ? int'(cur_slot) : pick_lowest(n, 1'b0);
                POL_PSJF: nxt = pick_lowest(n, 1'b0);
                default:  nxt = -1;
            endcase

            if (nxt >= 0 && (!cur_valid || nxt != int'(cur_slot))) begin
                cur_valid   = 1'b1;
                cur_slot    = 4'(nxt);
                slice_start = clock_now;
            end
            if (cur_valid && task_left[cur_slot] != 16'd0)
                task_left[cur_slot] = task_left[cur_slot] - 16'd1;
            clock_now = clock_now + 32'd1;
        end

        r.run_valid    = !halted && cur_valid;
        r.run_slot     = r.run_valid ? cur_slot : 4'd0;
        r.finish_valid = fin_v;
        r.finish_slot  = fin_s;
        r.all_done     = halted;
        return r;
    endfunction

    function automatic logic [31:0] reg_value(logic [1:0] idx);
        case (idx)
            REG_POLICY:     return {30'd0, sched_policy};
            REG_QUANTUM:    return {16'd0, slice_len};
            REG_TASK_COUNT: return {27'd0, slots_cfg};
            default:        return 32'd0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting: first ten printed, the rest counted
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // driver: presents backlog words, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic took;
        int   gap;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            took = start && !busy;
            if (took) begin
                words_taken <= words_taken + 1;
                if (i_in.func == FUNC_LOAD) store_task(i_in);
                else tick_results_due.push_back(run_tick());
            end
            if (took || !start) begin
                // fresh gap drawn per word; steady phases send back to back
                gap = took ? (steady_feed ? 0 : $urandom_range(0, 6)) : gap_left;
                if (gap == 0 && word_backlog.size() != 0) begin
                    i_in  <= word_backlog.pop_front();
                    start <= 1'b1;
                end else begin
                    start    <= 1'b0;
                    gap_left = (gap > 0) ? gap - 1 : 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: one result word per strobe, checked against the oldest tick
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sched_out want;
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (tick_results_due.size() == 0) begin
                check_field("pending tick words", 32'd1, 32'd0);
            end else begin
                want = tick_results_due.pop_front();
                check_field("tick_time", want.tick_time, o_out.tick_time);
                check_field("run_valid", 32'(want.run_valid), 32'(o_out.run_valid));
                check_field("run_slot", 32'(want.run_slot), 32'(o_out.run_slot));
                check_field("finish_valid", 32'(want.finish_valid), 32'(o_out.finish_valid));
                check_field("finish_slot", 32'(want.finish_slot), 32'(o_out.finish_slot));
                check_field("all_done", 32'(want.all_done), 32'(o_out.all_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no word in or out for too long ends the run
    // ------------------------------------------------------------------
    int taken_mark   = 0;
    int seen_mark    = 0;
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if (words_taken != taken_mark || results_seen != seen_mark) begin
            taken_mark   <= words_taken;
            seen_mark    <= results_seen;
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[multi_policy_task_scheduler] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_load(int s, logic [15:0] arr, logic [15:0] len);
        t_sched_in w;
        w.func    = FUNC_LOAD;
        w.slot    = 4'(s);
        w.arrival = arr;
        w.burst   = len;
        word_backlog.push_back(w);
        words_queued++;
    endtask

    task automatic push_tick();
        t_sched_in w;
        // payload fields are don't-care on a tick; fill with noise
        w.func    = FUNC_TICK;
        w.slot    = 4'($urandom_range(0, 15));
        w.arrival = 16'($urandom);
        w.burst   = 16'($urandom);
        word_backlog.push_back(w);
        words_queued++;
    endtask

    // all words taken, all results in, then let the last tick wind down
    task automatic wait_drained();
        while (words_taken != words_queued || tick_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;   // access cycle, pready tied high
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic verify_reg(logic [1:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        check_field("register read", reg_value(idx), rd);
    endtask

    task automatic program_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_POLICY:     sched_policy = value[1:0];
            REG_QUANTUM:    slice_len    = value[15:0];
            REG_TASK_COUNT: slots_cfg    = value[4:0];
            default:        ;   // unused address, write dropped
        endcase
        if (idx != REG_UNUSED) verify_reg(idx);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int          phase;
        int          count;
        int          ticks;
        int          lo;
        bit          conserve;
        logic [31:0] qv;
        logic [31:0] tc;
        logic [15:0] arr;
        logic [15:0] len;

        for (int i = 0; i < SLOTS; i++) begin
            task_arrival[i] = '0;
            task_left[i]    = '0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the register file
        verify_reg(REG_POLICY);
        verify_reg(REG_QUANTUM);
        verify_reg(REG_TASK_COUNT);

        // Directed: fill every slot in arrival order before the first tick,
        // so the scan never touches an unwritten entry. Covers a zero burst,
        // the longest burst and the last possible arrival.
        push_load(0, 16'd0, 16'd0);
        push_load(1, 16'd0, 16'hFFFF);
        for (int s = 2; s < SLOTS - 1; s++)
            push_load(s, 16'(s - 1), 16'($urandom_range(2, 40)));
        push_load(SLOTS - 1, 16'hFFFF, 16'd1);
        repeat (8) push_tick();

        // Random phases. Each starts idle: program registers, then a mix of
        // reloads and ticks. Once many tasks have retired, every short task
        // gets topped up with a long burst so the all-done state is saved
        // for the last phase.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            conserve = !halted && retire_cnt >= 5'd8;

            program_reg(REG_POLICY, {30'd0, (phase < 8) ? POLICY_ORDER[phase % 4]
                                                        : POLICY_ORDER[$urandom_range(0, 3)]});

            if (phase == 0)      qv = 32'd1;
            else if (phase == 1) qv = 32'd0;        // acts as a slice of one
            else if (phase == 2) qv = 32'd65535;
            else if ($urandom_range(0, 2) != 0) qv = $urandom_range(1, 8);
            else qv = $urandom_range(1, 65535);
            program_reg(REG_QUANTUM, qv);

            // keep enough slots in use that a phase cannot finish them all
            lo = int'(retire_cnt) + 6;
            if (lo > SLOTS) lo = SLOTS;
            if (phase == 4 || $urandom_range(0, 4) == 0) tc = 32'd31;  // clamps to 16
            else if (conserve) tc = $urandom_range(2, SLOTS);
            else tc = $urandom_range(lo, SLOTS);
            program_reg(REG_TASK_COUNT, tc);

            if (phase == 5) program_reg(REG_UNUSED, $urandom);

            steady_feed = ($urandom_range(0, 3) == 0);

            if (conserve) begin
                for (int s = 0; s < SLOTS; s++)
                    if (task_left[s] < 16'(LONG_BURST))
                        push_load(s, task_arrival[s], 16'($urandom_range(LONG_BURST, 65535)));
            end

            count = $urandom_range(40, 60);
            ticks = 0;
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // mostly arrivals a little ahead of the clock, some noise
                    if ($urandom_range(0, 9) == 0) arr = 16'($urandom);
                    else arr = clock_now[15:0] + 16'(ticks) + 16'($urandom_range(0, 24));
                    if (conserve) len = 16'($urandom_range(LONG_BURST, 65535));
                    else if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(0, 3));
                    else len = 16'($urandom_range(4, 60));
                    push_load($urandom_range(0, SLOTS - 1), arr, len);
                end else begin
                    push_tick();
                    ticks++;
                end
            end
        end

        // Final phase: a single slot in use (count 0 acts as 1), a short task
        // on slot 0 under PSJF retires and ends the schedule; the remaining
        // ticks must report the frozen time.
        wait_drained();
        steady_feed = 1'b0;
        program_reg(REG_POLICY, {30'd0, POL_PSJF});
        program_reg(REG_TASK_COUNT, 32'd0);
        program_reg(REG_QUANTUM, $urandom_range(1, 65535));
        push_load(0, clock_now[15:0] + 16'd1, 16'd3);
        repeat (20) push_tick();

        wait_drained();
        program_reg(REG_POLICY, {30'd0, POL_RR});
        program_reg(REG_TASK_COUNT, 32'd1);
        push_load($urandom_range(0, SLOTS - 1), clock_now[15:0], 16'd5);
        repeat (5) push_tick();

        wait_drained();
        if (mismatches == 0 && tick_results_due.size() == 0)
            $display("[multi_policy_task_scheduler] OK");
        else
            $display("[multi_policy_task_scheduler] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/msched_pkg.sv
src/msched_ram.sv
src/msched_ctrl.sv
src/msched_dp.sv
src/multi_policy_task_scheduler.sv
test/multi_policy_task_scheduler_test.sv
